FILE: sv/checksummed_ring_record_log_macros.svh
// Assertion macros shared by the checker of the record log.
// Depends on nothing; the including file supplies the clock and reset names.
`ifndef CHECKSUMMED_RING_RECORD_LOG_MACROS_SVH
`define CHECKSUMMED_RING_RECORD_LOG_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRL_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("record log property failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define CRL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("record log property failed in the next cycle");

`endif

FILE: sv/crl_pkg.sv
// Types and constants of the checksummed ring record log.
// Depends on nothing; used by the top level.
`timescale 1ns / 1ps

package crl_pkg;

  localparam logic       CMD_APPEND = 1'b0;
  localparam logic       CMD_READ   = 1'b1;

  localparam int         CFG_AW        = 3;
  localparam logic       REG_REC_BYTES = 1'b0;
  localparam logic       REG_SLOT_COUNT = 1'b1;

  localparam logic [4:0] REC_BYTES_RESET  = 5'd16;
  localparam logic [5:0] SLOT_COUNT_RESET = 6'd32;

  localparam logic [7:0] ERASED     = 8'hFF;
  localparam int         NUM_COPIES = 4;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_AWR   = 7'b0000100,
    S_ACHK  = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_RES   = 7'b1000000
  } crl_state_t;

endpackage

FILE: sv/crl_if.sv
// Valid/ready channel interfaces for requests and results of the record log.
// Depends on nothing.
`timescale 1ns / 1ps

interface crl_req_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;
  logic [4:0] age;

  modport source (output valid, cmd, data_byte, age, input ready);
  modport sink (input valid, cmd, data_byte, age, output ready);
endinterface

interface crl_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       ok;
  logic       last;

  modport source (output valid, out_byte, ok, last, input ready);
  modport sink (input valid, out_byte, ok, last, output ready);
endinterface

FILE: sv/crl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module crl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 544
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/checksummed_ring_record_log.sv
// Checksummed ring record log: an append writes one byte (S_AWR), and on the last byte of
// a record also the checksum (S_ACHK) and an acknowledge (S_RES). A read first verifies
// the checksum through the single read port of the log RAM, then streams one byte per
// cycle while the consumer takes them. Requests are taken one at a time.
// After reset the log RAM is filled with 0xFF, one byte per cycle, all
// MAX_SLOTS*(MAX_RECORD_BYTES+1) bytes, before the first request is taken.
`timescale 1ns / 1ps

module checksummed_ring_record_log
  import crl_pkg::*;
#(
  parameter int MAX_SLOTS        = 32,
  parameter int MAX_RECORD_BYTES = 16
) (
  input  logic              clk,
  input  logic              rst,
  crl_req_if.sink           req,
  crl_res_if.source         res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int DEPTH = MAX_SLOTS * (MAX_RECORD_BYTES + 1);
  localparam int AW    = $clog2(DEPTH);
  localparam int HW    = $clog2(MAX_SLOTS);
  localparam int CW    = $clog2(MAX_RECORD_BYTES + 1);
  localparam int SW    = $clog2(MAX_SLOTS + 1);
  localparam int PW    = HW + CW + 1;

  crl_state_t    state;
  logic [AW-1:0] clr_addr;
  logic [4:0]    rec_bytes;
  logic [5:0]    slot_count;
  logic [HW-1:0] head;
  logic [CW-1:0] pos;
  logic [7:0]    sum;
  logic [7:0]    ptr_copy [NUM_COPIES];
  logic [7:0]    data_r;
  logic [HW-1:0] rd_slot;
  logic [CW-1:0] idx;
  logic          issue_done;
  logic          scan_vld;
  logic          scan_last;
  logic [7:0]    acc;
  logic          nz;
  logic          rd_pend;
  logic          res_ok;
  logic          out_valid;
  logic [7:0]    out_byte_r;
  logic          ok_r;
  logic          last_r;

  logic [CW-1:0] rl_eff;
  logic [SW-1:0] slots_eff;
  logic [SW-1:0] head_inc;
  logic [HW-1:0] head_new;
  logic [CW-1:0] pos_eff;
  logic [CW-1:0] pos_inc;
  logic          age_bad;
  logic [HW-1:0] slot_calc;
  logic [HW-1:0] slot_sel;
  logic [PW-1:0] prod;
  logic [AW-1:0] base;
  logic [CW-1:0] roff;
  logic          can_load;
  logic          res_load;
  logic          emit_end;
  logic          cfg_wr;
  logic          cfg_sel;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  assign rl_eff = (rec_bytes == '0) ? CW'(1) :
                  (32'(rec_bytes) > MAX_RECORD_BYTES) ? CW'(MAX_RECORD_BYTES) :
                  CW'(rec_bytes);
  assign slots_eff = (slot_count == '0) ? SW'(1) :
                     (32'(slot_count) > MAX_SLOTS) ? SW'(MAX_SLOTS) :
                     SW'(slot_count);

  assign head_inc = SW'(head) + SW'(1);
  assign head_new = (head_inc >= slots_eff) ? '0 : HW'(head_inc);
  assign pos_eff  = (pos >= rl_eff) ? '0 : pos;
  assign pos_inc  = pos + CW'(1);

  assign age_bad   = 32'(req.age) >= 32'(slots_eff);
  assign slot_calc = (32'(head) >= 32'(req.age)) ? HW'(32'(head) - 32'(req.age)) :
                     HW'(32'(slots_eff) - 32'(req.age) + 32'(head));

  assign slot_sel = (state == S_AWR || state == S_ACHK) ? head : rd_slot;
  assign prod     = PW'(slot_sel) * (PW'(rl_eff) + PW'(1));
  assign base     = AW'(prod);

  assign can_load = !out_valid || res.ready;
  assign res_load = can_load && ((state == S_EMIT && rd_pend) || state == S_RES);
  assign emit_end = (idx == rl_eff - CW'(1));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = base + AW'(pos);
    ram_wdata = data_r;
    ram_re    = 1'b0;
    roff      = idx;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = ERASED;
      end
      S_AWR: begin
        ram_we = 1'b1;
      end
      S_ACHK: begin
        ram_we    = 1'b1;
        ram_waddr = base + AW'(rl_eff);
        ram_wdata = sum;
      end
      S_SCAN: begin
        ram_re = !issue_done;
      end
      S_EMIT: begin
        ram_re = !rd_pend || (can_load && !emit_end);
        roff   = rd_pend ? idx + CW'(1) : idx;
      end
      default: begin
      end
    endcase
  end

  assign ram_raddr = base + AW'(roff);

  crl_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_log_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = paddr[CFG_AW-1];
  assign prdata  = (cfg_sel == REG_SLOT_COUNT) ? 32'(slot_count) : 32'(rec_bytes);
  assign pready  = 1'b1;

  assign req.ready    = (state == S_IDLE);
  assign res.valid    = out_valid;
  assign res.out_byte = out_byte_r;
  assign res.ok       = ok_r;
  assign res.last     = last_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      rec_bytes  <= REC_BYTES_RESET;
      slot_count <= SLOT_COUNT_RESET;
      head       <= '0;
      pos        <= '0;
      sum        <= '0;
      for (int k = 0; k < NUM_COPIES; k++) begin
        ptr_copy[k] <= ERASED;
      end
      issue_done <= 1'b0;
      scan_vld   <= 1'b0;
      rd_pend    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && res.ready && !res_load) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr) begin
        if (cfg_sel == REG_SLOT_COUNT) begin
          slot_count <= pwdata[5:0];
        end else begin
          rec_bytes <= pwdata[4:0];
        end
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            data_r <= req.data_byte;
            if (req.cmd == CMD_APPEND) begin
              pos <= pos_eff;
              if (pos >= rl_eff) begin
                sum <= '0;
              end
              if (pos_eff == '0) begin
                head <= head_new;
                if (ptr_copy[0] == ERASED) begin
                  ptr_copy[0] <= 8'(head_new);
                end else if (ptr_copy[1] == ERASED) begin
                  ptr_copy[1] <= 8'(head_new);
                end else if (ptr_copy[2] == ERASED) begin
                  ptr_copy[2] <= 8'(head_new);
                end else if (ptr_copy[3] == ERASED) begin
                  ptr_copy[3] <= 8'(head_new);
                end else begin
                  ptr_copy[0] <= 8'(head_new);
                  ptr_copy[1] <= ERASED;
                  ptr_copy[2] <= ERASED;
                  ptr_copy[3] <= ERASED;
                end
              end
              state <= S_AWR;
            end else if (age_bad) begin
              res_ok <= 1'b0;
              state  <= S_RES;
            end else begin
              rd_slot    <= slot_calc;
              idx        <= '0;
              issue_done <= 1'b0;
              scan_vld   <= 1'b0;
              acc        <= '0;
              nz         <= 1'b0;
              state      <= S_SCAN;
            end
          end
        end
        S_AWR: begin
          sum <= sum + data_r;
          if (pos_inc >= rl_eff) begin
            state <= S_ACHK;
          end else begin
            pos   <= pos_inc;
            state <= S_IDLE;
          end
        end
        S_ACHK: begin
          pos    <= '0;
          sum    <= '0;
          res_ok <= 1'b1;
          state  <= S_RES;
        end
        S_SCAN: begin
          if (!issue_done) begin
            scan_vld  <= 1'b1;
            scan_last <= (idx == rl_eff);
            if (idx == rl_eff) begin
              issue_done <= 1'b1;
            end else begin
              idx <= idx + CW'(1);
            end
          end else begin
            scan_vld <= 1'b0;
          end
          if (scan_vld) begin
            if (scan_last) begin
              idx     <= '0;
              rd_pend <= 1'b0;
              if (acc == ram_rdata && nz) begin
                state <= S_EMIT;
              end else begin
                res_ok <= 1'b0;
                state  <= S_RES;
              end
            end else begin
              acc <= acc + ram_rdata;
              nz  <= nz || (ram_rdata != 8'h00);
            end
          end
        end
        S_EMIT: begin
          if (!rd_pend) begin
            rd_pend <= 1'b1;
          end else if (can_load) begin
            out_valid  <= 1'b1;
            out_byte_r <= ram_rdata;
            ok_r       <= 1'b1;
            last_r     <= emit_end;
            if (emit_end) begin
              rd_pend <= 1'b0;
              state   <= S_IDLE;
            end else begin
              idx <= idx + CW'(1);
            end
          end
        end
        S_RES: begin
          if (can_load) begin
            out_valid  <= 1'b1;
            out_byte_r <= 8'h00;
            ok_r       <= res_ok;
            last_r     <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/crl_checker.sv
// Port-level checker of the record log and its bind to the top level.
// Depends on checksummed_ring_record_log_macros.svh.
`timescale 1ns / 1ps
`include "checksummed_ring_record_log_macros.svh"

module crl_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] res_out_byte,
  input logic       res_ok,
  input logic       res_last,
  input logic       pready
);

  // A failed read or a rejected age is a single zero result that closes the request.
  `CRL_ASSERT_SAME(a_fail_single, clk, rst, res_valid && !res_ok, res_last && res_out_byte == 8'h00)

  // Record bytes stream back to back while the consumer keeps taking them.
  `CRL_ASSERT_NEXT(a_stream_gapless, clk, rst, res_valid && res_ready && !res_last, res_valid)

  // Leaving reset, the log is being erased and no result is pending.
  `CRL_ASSERT_SAME(a_reset_quiet, clk, rst, $past(rst), !req_ready && !res_valid && pready)

  `CRL_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid)

endmodule

bind checksummed_ring_record_log crl_checker u_crl_checker (
  .clk          (clk),
  .rst          (rst),
  .req_ready    (req.ready),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .res_out_byte (res.out_byte),
  .res_ok       (res.ok),
  .res_last     (res.last),
  .pready       (pready)
);
